// ===== rtl/core/framebuffer_line_draw_defines.svh =====
// Assertion helpers for the framebuffer line engine.
// All checks are sampled on i_clk and are off while i_rst_n is low.
`ifndef FRAMEBUFFER_LINE_DRAW_DEFINES_SVH
`define FRAMEBUFFER_LINE_DRAW_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define FLD_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);

`define FLD_ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define FLD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define FLD_ASSERT_ALWAYS(lbl, expr, msg)
`define FLD_ASSERT_IMPLIES(lbl, ante, cons, msg)
`define FLD_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ===== rtl/core/fld_pkg.sv =====
package fld_pkg;

    localparam int SCREEN_WIDTH  = 128;
    localparam int SCREEN_HEIGHT = 64;
    localparam int BYTES_PER_ROW = SCREEN_WIDTH / 8;

    localparam int STORE_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int COORD_W     = 8;
    localparam int KIND_W      = 2;
    localparam int DATA_W      = 8;
    localparam int ERR_W       = COORD_W + 3;
    localparam int IDX_W       = 16;
    localparam logic [DATA_W-1:0] LEFT_BIT = 8'h80;

    localparam int FQ_DEPTH = 2;
    localparam int FQ_AW    = $clog2(FQ_DEPTH);
    localparam int FQ_CW    = $clog2(FQ_DEPTH + 1);

    localparam logic [KIND_W-1:0] KIND_LINE  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

    typedef enum logic [1:0] {
        OP_LINE  = 2'd0,
        OP_CLEAR = 2'd1,
        OP_READ  = 2'd2,
        OP_NOP   = 2'd3
    } t_op;

    typedef struct packed {
        t_op                op;
        logic [KIND_W-1:0]  kind;
        logic               color;
        logic [COORD_W-1:0] ax;
        logic [COORD_W-1:0] ay;
        logic [COORD_W-1:0] bx;
        logic [COORD_W-1:0] by;
        logic [COORD_W-1:0] dx;
        logic [COORD_W-1:0] dy;
        logic               x_neg;
        logic               y_neg;
        logic [ERR_W-1:0]   err0;
        logic [ADDR_W-1:0]  ridx;
    } t_cmd;

    typedef struct packed {
        logic init_busy;
        logic pop;
    } t_bk_stat;

    typedef struct packed {
        logic [FQ_CW-1:0] count;
        logic             push;
    } t_fq_stat;

endpackage

// ===== rtl/core/fld_front.sv =====
module fld_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [fld_pkg::KIND_W-1:0]  i_kind,
    input  logic                        i_color,
    input  logic [fld_pkg::COORD_W-1:0] i_start_x,
    input  logic [fld_pkg::COORD_W-1:0] i_start_y,
    input  logic [fld_pkg::COORD_W-1:0] i_end_x,
    input  logic [fld_pkg::COORD_W-1:0] i_end_y,
    input  logic [fld_pkg::ADDR_W-1:0]  i_read_index,
    output fld_pkg::t_cmd               o_cmd,
    output logic                        o_cmd_valid,
    input  fld_pkg::t_bk_stat           i_bk_stat,
    output fld_pkg::t_fq_stat           o_fq_stat
);
    import fld_pkg::*;

    t_cmd             r_q [FQ_DEPTH];
    logic [FQ_AW-1:0] r_wp, n_wp;
    logic [FQ_AW-1:0] r_rp, n_rp;
    logic [FQ_CW-1:0] r_cnt, n_cnt;
    t_cmd             dec;
    logic             push;
    logic             pop;

    // classify the beat and precompute the line setup
    always_comb begin
        dec       = '0;
        dec.kind  = i_kind;
        dec.color = i_color;
        dec.ax    = i_start_x;
        dec.ay    = i_start_y;
        dec.bx    = i_end_x;
        dec.by    = i_end_y;
        dec.ridx  = i_read_index;
        case (i_kind)
            KIND_LINE:  dec.op = OP_LINE;
            KIND_CLEAR: dec.op = OP_CLEAR;
            KIND_READ:  dec.op = OP_READ;
            default:    dec.op = OP_NOP;
        endcase
        dec.dx    = (i_end_x >= i_start_x) ? i_end_x - i_start_x : i_start_x - i_end_x;
        dec.dy    = (i_end_y >= i_start_y) ? i_end_y - i_start_y : i_start_y - i_end_y;
        dec.x_neg = !(i_start_x < i_end_x);
        dec.y_neg = !(i_start_y < i_end_y);
        dec.err0  = ERR_W'(dec.dx) - ERR_W'(dec.dy);
    end

    assign o_in_ready  = (r_cnt != FQ_CW'(FQ_DEPTH)) && !i_bk_stat.init_busy;
    assign push        = i_in_valid && o_in_ready;
    assign pop         = i_bk_stat.pop;
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_q[r_rp];

    assign o_fq_stat.count = r_cnt;
    assign o_fq_stat.push  = push;

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (push) begin
            n_wp = (r_wp == FQ_AW'(FQ_DEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (pop) begin
            n_rp = (r_rp == FQ_AW'(FQ_DEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        if (push && !pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (pop && !push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= dec;
        end
    end

endmodule

// ===== rtl/core/fld_exec.sv =====
module fld_exec (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  fld_pkg::t_cmd               i_cmd,
    input  logic                        i_cmd_valid,
    output fld_pkg::t_bk_stat           o_bk_stat,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [fld_pkg::KIND_W-1:0]  o_reply_kind,
    output logic [fld_pkg::DATA_W-1:0]  o_read_data
);
    import fld_pkg::*;

    typedef enum logic [6:0] {
        S_CLR  = 7'b0000001,
        S_IDLE = 7'b0000010,
        S_LRD  = 7'b0000100,
        S_LWR  = 7'b0001000,
        S_RRD  = 7'b0010000,
        S_RCAP = 7'b0100000,
        S_DONE = 7'b1000000
    } t_state;

    t_state              r_state, n_state;
    logic [ADDR_W-1:0]   r_clr_cnt, n_clr_cnt;
    logic                r_clr_reply, n_clr_reply;
    logic [COORD_W-1:0]  r_ax, n_ax;
    logic [COORD_W-1:0]  r_ay, n_ay;
    logic [COORD_W-1:0]  r_bx, n_bx;
    logic [COORD_W-1:0]  r_by, n_by;
    logic [COORD_W-1:0]  r_dx, n_dx;
    logic [COORD_W-1:0]  r_dy, n_dy;
    logic                r_x_neg, n_x_neg;
    logic                r_y_neg, n_y_neg;
    logic [ERR_W-1:0]    r_err, n_err;
    logic                r_color, n_color;
    logic [KIND_W-1:0]   r_kind, n_kind;
    logic [ADDR_W-1:0]   r_ridx, n_ridx;
    logic [ADDR_W-1:0]   r_idx, n_idx;
    logic [DATA_W-1:0]   r_mask, n_mask;
    logic                r_pix_ok, n_pix_ok;
    logic [DATA_W-1:0]   r_res_data, n_res_data;
    logic                r_out_valid, n_out_valid;
    logic [KIND_W-1:0]   r_out_kind, n_out_kind;
    logic [DATA_W-1:0]   r_out_data, n_out_data;

    logic [DATA_W-1:0]   r_mem [STORE_DEPTH];
    logic [DATA_W-1:0]   r_rd_data;
    logic                mem_we;
    logic [ADDR_W-1:0]   mem_waddr;
    logic [DATA_W-1:0]   mem_wdata;
    logic [ADDR_W-1:0]   mem_raddr;

    logic                pop;
    logic [IDX_W-1:0]    full_idx;
    logic                on_screen;
    logic signed [ERR_W:0] e2;
    logic signed [ERR_W:0] neg_dy;
    logic signed [ERR_W:0] dx_s;
    logic signed [ERR_W:0] err_a;
    logic signed [ERR_W:0] err_b;
    logic                step_x;
    logic                step_y;
    logic                at_end;

    assign full_idx  = IDX_W'(r_ay) * IDX_W'(BYTES_PER_ROW) + IDX_W'(r_ax >> 3);
    assign on_screen = ({1'b0, r_ax} < (COORD_W + 1)'(SCREEN_WIDTH))
                    && ({1'b0, r_ay} < (COORD_W + 1)'(SCREEN_HEIGHT))
                    && (full_idx < IDX_W'(STORE_DEPTH));

    // Bresenham error update
    assign e2     = $signed({r_err[ERR_W-1], r_err}) <<< 1;
    assign dx_s   = $signed((ERR_W + 1)'(r_dx));
    assign neg_dy = -$signed((ERR_W + 1)'(r_dy));
    assign step_x = (e2 > neg_dy);
    assign step_y = (e2 < dx_s);
    assign err_a  = step_x ? $signed({r_err[ERR_W-1], r_err}) + neg_dy
                           : $signed({r_err[ERR_W-1], r_err});
    assign err_b  = step_y ? err_a + dx_s : err_a;
    assign at_end = (r_ax == r_bx) && (r_ay == r_by);

    always_comb begin
        n_state     = r_state;
        n_clr_cnt   = r_clr_cnt;
        n_clr_reply = r_clr_reply;
        n_ax        = r_ax;
        n_ay        = r_ay;
        n_bx        = r_bx;
        n_by        = r_by;
        n_dx        = r_dx;
        n_dy        = r_dy;
        n_x_neg     = r_x_neg;
        n_y_neg     = r_y_neg;
        n_err       = r_err;
        n_color     = r_color;
        n_kind      = r_kind;
        n_ridx      = r_ridx;
        n_idx       = r_idx;
        n_mask      = r_mask;
        n_pix_ok    = r_pix_ok;
        n_res_data  = r_res_data;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_kind  = r_out_kind;
        n_out_data  = r_out_data;
        pop         = 1'b0;
        mem_we      = 1'b0;
        mem_waddr   = r_idx;
        mem_wdata   = '0;
        mem_raddr   = r_ridx;

        case (r_state)
            S_CLR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr_cnt;
                n_clr_cnt = r_clr_cnt + 1'b1;
                if (r_clr_cnt == ADDR_W'(STORE_DEPTH - 1)) begin
                    n_state = r_clr_reply ? S_DONE : S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_cmd_valid) begin
                    pop        = 1'b1;
                    n_kind     = i_cmd.kind;
                    n_color    = i_cmd.color;
                    n_ax       = i_cmd.ax;
                    n_ay       = i_cmd.ay;
                    n_bx       = i_cmd.bx;
                    n_by       = i_cmd.by;
                    n_dx       = i_cmd.dx;
                    n_dy       = i_cmd.dy;
                    n_x_neg    = i_cmd.x_neg;
                    n_y_neg    = i_cmd.y_neg;
                    n_err      = i_cmd.err0;
                    n_ridx     = i_cmd.ridx;
                    n_res_data = '0;
                    case (i_cmd.op)
                        OP_LINE: n_state = S_LRD;
                        OP_CLEAR: begin
                            n_clr_cnt   = '0;
                            n_clr_reply = 1'b1;
                            n_state     = S_CLR;
                        end
                        OP_READ: n_state = S_RRD;
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_LRD: begin
                mem_raddr = full_idx[ADDR_W-1:0];
                n_idx     = full_idx[ADDR_W-1:0];
                n_pix_ok  = on_screen;
                n_mask    = LEFT_BIT >> r_ax[2:0];
                n_state   = S_LWR;
            end
            S_LWR: begin
                mem_we    = r_pix_ok;
                mem_waddr = r_idx;
                mem_wdata = r_color ? (r_rd_data | r_mask) : (r_rd_data & ~r_mask);
                if (at_end) begin
                    n_state = S_DONE;
                end else begin
                    n_err = err_b[ERR_W-1:0];
                    if (step_x) begin
                        n_ax = r_x_neg ? r_ax - 1'b1 : r_ax + 1'b1;
                    end
                    if (step_y) begin
                        n_ay = r_y_neg ? r_ay - 1'b1 : r_ay + 1'b1;
                    end
                    n_state = S_LRD;
                end
            end
            S_RRD: begin
                mem_raddr = r_ridx;
                n_state   = S_RCAP;
            end
            S_RCAP: begin
                n_res_data = r_rd_data;
                n_state    = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out_kind  = r_kind;
                    n_out_data  = r_res_data;
                    n_clr_reply = 1'b0;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr_cnt   <= '0;
            r_clr_reply <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_cnt   <= n_clr_cnt;
            r_clr_reply <= n_clr_reply;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ax       <= n_ax;
        r_ay       <= n_ay;
        r_bx       <= n_bx;
        r_by       <= n_by;
        r_dx       <= n_dx;
        r_dy       <= n_dy;
        r_x_neg    <= n_x_neg;
        r_y_neg    <= n_y_neg;
        r_err      <= n_err;
        r_color    <= n_color;
        r_kind     <= n_kind;
        r_ridx     <= n_ridx;
        r_idx      <= n_idx;
        r_mask     <= n_mask;
        r_pix_ok   <= n_pix_ok;
        r_res_data <= n_res_data;
        r_out_kind <= n_out_kind;
        r_out_data <= n_out_data;
    end

    // pixel store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= r_mem[mem_raddr];
    end

    assign o_bk_stat.init_busy = (r_state == S_CLR) && !r_clr_reply;
    assign o_bk_stat.pop       = pop;
    assign o_out_valid         = r_out_valid;
    assign o_reply_kind        = r_out_kind;
    assign o_read_data         = r_out_data;

endmodule

// ===== rtl/core/framebuffer_line_draw.sv =====
// Monochrome 128x64 framebuffer (1024 bytes, MSB leftmost) with a Bresenham line
// drawer, a whole-store clear and a single-byte read; every beat returns one reply
// echoing its kind, with the byte for a read and zero otherwise. Each pixel is a
// read-modify-write of its store byte, which sets the pace. After reset a clearing
// pass over all 1024 bytes runs, and o_in_ready stays low until it finishes. Two
// commands can queue ahead of the drawer.
`include "framebuffer_line_draw_defines.svh"

module framebuffer_line_draw (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [fld_pkg::KIND_W-1:0]  i_kind,
    input  logic                        i_color,
    input  logic [fld_pkg::COORD_W-1:0] i_start_x,
    input  logic [fld_pkg::COORD_W-1:0] i_start_y,
    input  logic [fld_pkg::COORD_W-1:0] i_end_x,
    input  logic [fld_pkg::COORD_W-1:0] i_end_y,
    input  logic [fld_pkg::ADDR_W-1:0]  i_read_index,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [fld_pkg::KIND_W-1:0]  o_reply_kind,
    output logic [fld_pkg::DATA_W-1:0]  o_read_data
);
    import fld_pkg::*;

    t_cmd     cmd;
    logic     cmd_valid;
    t_bk_stat bk_stat;
    t_fq_stat fq_stat;

    fld_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_kind       (i_kind),
        .i_color      (i_color),
        .i_start_x    (i_start_x),
        .i_start_y    (i_start_y),
        .i_end_x      (i_end_x),
        .i_end_y      (i_end_y),
        .i_read_index (i_read_index),
        .o_cmd        (cmd),
        .o_cmd_valid  (cmd_valid),
        .i_bk_stat    (bk_stat),
        .o_fq_stat    (fq_stat)
    );

    fld_exec u_exec (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_cmd_valid  (cmd_valid),
        .o_bk_stat    (bk_stat),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_reply_kind (o_reply_kind),
        .o_read_data  (o_read_data)
    );

    `FLD_ASSERT_IMPLIES(a_no_push_full, fq_stat.push, fq_stat.count != FQ_CW'(FQ_DEPTH), "push into full queue")
    `FLD_ASSERT_IMPLIES(a_no_pop_empty, bk_stat.pop, fq_stat.count != '0, "pop from empty queue")
    `FLD_ASSERT_IMPLIES(a_init_blocks, bk_stat.init_busy, !o_in_ready, "beat taken during init clear")
    `FLD_ASSERT_IMPLIES(a_init_after_rst, $rose(i_rst_n), bk_stat.init_busy, "no init clear after reset")

endmodule

// ===== test/framebuffer_line_draw_tb.sv =====
module framebuffer_line_draw_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fld_pkg::*;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [DATA_W-1:0] data;
    } t_fb_reply;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_ready;
    logic [KIND_W-1:0]   i_kind;
    logic                i_color;
    logic [COORD_W-1:0]  i_start_x;
    logic [COORD_W-1:0]  i_start_y;
    logic [COORD_W-1:0]  i_end_x;
    logic [COORD_W-1:0]  i_end_y;
    logic [ADDR_W-1:0]   i_read_index;
    logic                o_out_valid;
    logic                i_out_ready;
    logic [KIND_W-1:0]   o_reply_kind;
    logic [DATA_W-1:0]   o_read_data;

    // shadow copy of the pixel store and the replies still owed by the block
    logic [DATA_W-1:0]   shadow_fb [STORE_DEPTH];
    t_fb_reply           pending_replies [$];

    int                  error_count = 0;
    bit                  steady_flow = 1'b0;

    // endpoints of the most recent random line, used to aim reads at it
    int                  last_x0, last_y0, last_x1, last_y1;

    framebuffer_line_draw u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_kind       (i_kind),
        .i_color      (i_color),
        .i_start_x    (i_start_x),
        .i_start_y    (i_start_y),
        .i_end_x      (i_end_x),
        .i_end_y      (i_end_y),
        .i_read_index (i_read_index),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_reply_kind (o_reply_kind),
        .o_read_data  (o_read_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #(100_000_000);
        $display("CHECKS FAILED");
        $finish;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        error_count++;
        if (error_count <= 100) begin
            $display("[%0t] mismatch: %s got 0x%0h expected 0x%0h", $time, what, got, want);
        end
    endtask

    function automatic int pick_gap();
        int r;
        if (steady_flow) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 70) begin
            return 0;
        end else if (r < 95) begin
            return $urandom_range(1, 4);
        end
        return $urandom_range(10, 60);
    endfunction

    // base plus a random offset in [-span, span], clamped to the coordinate range
    function automatic logic [COORD_W-1:0] near(input int base, input int span);
        int v;
        v = base + $urandom_range(0, 2 * span) - span;
        if (v < 0) begin
            v = 0;
        end
        if (v > 255) begin
            v = 255;
        end
        return v[COORD_W-1:0];
    endfunction

    function automatic void paint_pixel(input logic color, input int x, input int y);
        int                idx;
        logic [DATA_W-1:0] mask;
        if (x < 0 || y < 0 || x >= SCREEN_WIDTH || y >= SCREEN_HEIGHT) begin
            return;
        end
        idx = y * BYTES_PER_ROW + x / 8;
        if (idx >= STORE_DEPTH) begin
            return;
        end
        mask = LEFT_BIT >> (x % 8);
        if (color) begin
            shadow_fb[idx] = shadow_fb[idx] | mask;
        end else begin
            shadow_fb[idx] = shadow_fb[idx] & ~mask;
        end
    endfunction

    function automatic void trace_line(input logic color, input int ax, input int ay,
                                       input int bx, input int by);
        int dx, dy, sx, sy, err, e2;
        dx  = (bx >= ax) ? bx - ax : ax - bx;
        dy  = (by >= ay) ? by - ay : ay - by;
        sx  = (ax < bx) ? 1 : -1;
        sy  = (ay < by) ? 1 : -1;
        err = dx - dy;
        for (int step = 0; step < 1024; step++) begin
            paint_pixel(color, ax, ay);
            if (ax == bx && ay == by) begin
                break;
            end
            e2 = err + err;
            if (e2 > -dy) begin
                err -= dy;
                ax  += sx;
            end
            if (e2 < dx) begin
                err += dx;
                ay  += sy;
            end
        end
    endfunction

    function automatic void predict_reply(input t_op op, input logic color,
                                          input int ax, input int ay, input int bx, input int by,
                                          input int ridx);
        t_fb_reply r;
        r.kind = op;
        r.data = '0;
        case (op)
            OP_LINE: begin
                trace_line(color, ax, ay, bx, by);
            end
            OP_CLEAR: begin
                foreach (shadow_fb[i]) shadow_fb[i] = '0;
            end
            OP_READ: begin
                r.data = shadow_fb[ridx];
            end
            default: begin
            end
        endcase
        pending_replies.push_back(r);
    endfunction

    // One input beat. Valid is only dropped when a gap is taken, so a
    // back-to-back beat keeps it high.
    task automatic send_beat(input t_op op, input logic color,
                             input logic [COORD_W-1:0] sx, input logic [COORD_W-1:0] sy,
                             input logic [COORD_W-1:0] ex, input logic [COORD_W-1:0] ey,
                             input logic [ADDR_W-1:0] ridx);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_kind       <= op;
        i_color      <= color;
        i_start_x    <= sx;
        i_start_y    <= sy;
        i_end_x      <= ex;
        i_end_y      <= ey;
        i_read_index <= ridx;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predict_reply(op, color, int'(sx), int'(sy), int'(ex), int'(ey), int'(ridx));
    endtask

    task automatic wait_for_drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_replies.size() != 0);
    endtask

    // reply checker and output-side stall generator
    initial begin
        t_fb_reply want;
        int        stall_left;
        stall_left = 0;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) begin
                if (pending_replies.size() == 0) begin
                    report_mismatch("unexpected reply, kind", int'(o_reply_kind), 0);
                end else begin
                    want = pending_replies.pop_front();
                    if (o_reply_kind !== want.kind) begin
                        report_mismatch("reply_kind", int'(o_reply_kind), int'(want.kind));
                    end
                    if (o_read_data !== want.data) begin
                        report_mismatch("read_data", int'(o_read_data), int'(want.data));
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
                stall_left = pick_gap();
            end
        end
    end

    task automatic test_reset_state();
        send_beat(OP_READ, 1'b0, 8'd0, 8'd0, 8'd0, 8'd0, 10'd0);
        send_beat(OP_READ, 1'b1, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 10'd1023);
    endtask

    task automatic test_line_shapes();
        send_beat(OP_LINE, 1'b1, 8'd0, 8'd0, 8'd127, 8'd63, 10'd0);
        send_beat(OP_READ, 1'b0, 8'd0, 8'd0, 8'd0, 8'd0, 10'd0);
        send_beat(OP_READ, 1'b0, 8'd0, 8'd0, 8'd0, 8'd0, 10'd1023);
        // single pixel
        send_beat(OP_LINE, 1'b1, 8'd5, 8'd7, 8'd5, 8'd7, 10'h2AA);
        send_beat(OP_READ, 1'b0, 8'd0, 8'd0, 8'd0, 8'd0, 10'd112);
        // horizontal erase of row 0, then a full-height column at the right edge
        send_beat(OP_LINE, 1'b0, 8'd0, 8'd0, 8'd127, 8'd0, 10'h155);
        send_beat(OP_READ, 1'b0, 8'd0, 8'd0, 8'd0, 8'd0, 10'd0);
        send_beat(OP_LINE, 1'b1, 8'd127, 8'd0, 8'd127, 8'd63, 10'd0);
        send_beat(OP_READ, 1'b0, 8'd0, 8'd0, 8'd0, 8'd0, 10'd15);
        // steep line walking upward
        send_beat(OP_LINE, 1'b1, 8'd13, 8'd63, 8'd10, 8'd0, 10'd0);
        send_beat(OP_READ, 1'b0, 8'd0, 8'd0, 8'd0, 8'd0, 10'd513);
    endtask

    task automatic test_offscreen();
        // starts far off screen and walks back onto it
        send_beat(OP_LINE, 1'b1, 8'd255, 8'd255, 8'd0, 8'd0, 10'd0);
        send_beat(OP_READ, 1'b0, 8'd0, 8'd0, 8'd0, 8'd0, 10'd1008);
        // never touches the screen
        send_beat(OP_LINE, 1'b1, 8'd200, 8'd100, 8'd255, 8'd200, 10'd0);
        send_beat(OP_LINE, 1'b1, 8'd0, 8'd255, 8'd255, 8'd0, 10'd0);
        send_beat(OP_READ, 1'b0, 8'd0, 8'd0, 8'd0, 8'd0, 10'd1016);
    endtask

    task automatic test_clear_and_nop();
        send_beat(OP_NOP, 1'b1, 8'hA5, 8'h5A, 8'hFF, 8'h00, 10'h3FF);
        send_beat(OP_READ, 1'b0, 8'd0, 8'd0, 8'd0, 8'd0, 10'd15);
        wait_for_drain();
        send_beat(OP_CLEAR, 1'b0, 8'd0, 8'd0, 8'd0, 8'd0, 10'd0);
        send_beat(OP_READ, 1'b0, 8'd0, 8'd0, 8'd0, 8'd0, 10'd15);
        send_beat(OP_READ, 1'b0, 8'd0, 8'd0, 8'd0, 8'd0, 10'd112);
    endtask

    task automatic test_random_traffic(input int n_items);
        int                 sent, next_drain, pick, lines, reads, t, x, y;
        logic               color;
        logic [COORD_W-1:0] sx, sy, ex, ey;
        sent       = 0;
        next_drain = 400;
        last_x0 = 0; last_y0 = 0; last_x1 = 127; last_y1 = 63;
        while (sent < n_items) begin
            steady_flow = (sent >= 700 && sent < 850);
            if (sent >= next_drain) begin
                wait_for_drain();
                next_drain += 400;
            end
            pick = $urandom_range(0, 99);
            if (pick < 2) begin
                send_beat(OP_CLEAR, 1'($urandom_range(0, 1)), COORD_W'($urandom),
                          COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom),
                          ADDR_W'($urandom));
                sent++;
            end else if (pick < 12) begin
                // unstructured noise, any kind, long lines included
                send_beat(t_op'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                          COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom),
                          COORD_W'($urandom), ADDR_W'($urandom));
                sent++;
            end else begin
                // a few lines, then reads aimed at the last one where it is on screen
                lines = $urandom_range(1, 3);
                for (int i = 0; i < lines; i++) begin
                    color = ($urandom_range(0, 9) < 7);
                    if ($urandom_range(0, 99) < 88) begin
                        sx = near(64, 72);
                        sy = near(32, 40);
                        ex = near(int'(sx), 20);
                        ey = near(int'(sy), 20);
                    end else begin
                        sx = COORD_W'($urandom); sy = COORD_W'($urandom);
                        ex = COORD_W'($urandom); ey = COORD_W'($urandom);
                    end
                    last_x0 = int'(sx); last_y0 = int'(sy);
                    last_x1 = int'(ex); last_y1 = int'(ey);
                    send_beat(OP_LINE, color, sx, sy, ex, ey, ADDR_W'($urandom));
                    sent++;
                end
                reads = $urandom_range(1, 4);
                for (int i = 0; i < reads; i++) begin
                    t = $urandom_range(0, 16);
                    x = last_x0 + (last_x1 - last_x0) * t / 16;
                    y = last_y0 + (last_y1 - last_y0) * t / 16;
                    if (x < SCREEN_WIDTH && y < SCREEN_HEIGHT) begin
                        send_beat(OP_READ, 1'($urandom_range(0, 1)), COORD_W'($urandom),
                                  COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom),
                                  ADDR_W'(y * BYTES_PER_ROW + x / 8));
                    end else begin
                        send_beat(OP_READ, 1'($urandom_range(0, 1)), COORD_W'($urandom),
                                  COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom),
                                  ADDR_W'($urandom));
                    end
                    sent++;
                end
            end
        end
        steady_flow = 1'b0;
    endtask

    initial begin
        foreach (shadow_fb[i]) shadow_fb[i] = '0;
        i_rst_n      <= 1'b0;
        i_in_valid   <= 1'b0;
        i_kind       <= OP_LINE;
        i_color      <= 1'b0;
        i_start_x    <= '0;
        i_start_y    <= '0;
        i_end_x      <= '0;
        i_end_y      <= '0;
        i_read_index <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_line_shapes();
        test_offscreen();
        test_clear_and_nop();
        test_random_traffic(1580);

        wait_for_drain();
        // a clear is the slowest item; give any stray reply time to show up
        repeat (1100) @(posedge i_clk);
        if (error_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
